FILE: sv/pnt_pkg.sv
// Shared types and constants for the pixel normalize tensor writer.
package pnt_pkg;

    localparam int DIM_W     = 13;
    localparam int COUNT_W   = 24;
    localparam int ADDR_W    = 26;
    localparam int VAL_W     = 32;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 64;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = PIX_W + 1 + VAL_W;
    localparam int DIFF_W    = PROD_W + 1;

    localparam logic [DIM_W-1:0]  DIM_RST  = 13'd640;
    localparam logic [COEF_W-1:0] COEF_RST = 64'h0010_0000_0000_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX  = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_CH    = 3'd0,
        CFG_INTERLEAVED = 3'd1,
        CFG_WIDTH       = 3'd2,
        CFG_HEIGHT      = 3'd3,
        CFG_CH0_COEF    = 3'd4,
        CFG_CH1_COEF    = 3'd5,
        CFG_CH2_COEF    = 3'd6
    } cfg_idx_t;

    typedef enum logic [CH_W-1:0] {
        CH_0 = 2'd0,
        CH_1 = 2'd1,
        CH_2 = 2'd2
    } ch_t;

    typedef logic [NUM_CH-1:0][COEF_W-1:0] coef_set_t;

    // One accepted pixel, classified by the front end.
    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] pixel;
        logic                         three;
        logic                         fend;
        logic [ADDR_W-1:0]            addr_start;
        logic [ADDR_W-1:0]            addr_step;
    } pix_desc_t;

    // One result word.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] addr;
        logic [CH_W-1:0]   ch;
        logic              clipped;
        logic              fend;
        logic              last;
    } result_t;

endpackage

FILE: sv/pixel_normalize_tensor_writer_unit.sv
// Top level of the pixel normalize tensor writer.
// A taken pixel passes the descriptor queue, the multiply register and the result queue.
// Throughput: one result word per cycle from the single multiply stage while the
// result queue has room, so a three channel pixel gives three words and a grey one.
// Reset: rst_n clears the pixel counter and queues and loads the register defaults.
module pixel_normalize_tensor_writer_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_write,
    input  logic [pnt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pnt_pkg::COEF_W-1:0]         cfg_data,
    // pixel side
    input  logic                               push,
    output logic                               full,
    input  logic [pnt_pkg::PIX_W-1:0]          pixel_ch0,
    input  logic [pnt_pkg::PIX_W-1:0]          pixel_ch1,
    input  logic [pnt_pkg::PIX_W-1:0]          pixel_ch2,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output logic signed [pnt_pkg::VAL_W-1:0]   norm_value,
    output logic [pnt_pkg::ADDR_W-1:0]         tensor_address,
    output logic [pnt_pkg::CH_W-1:0]           channel_index,
    output logic                               clipped,
    output logic                               frame_end,
    output logic                               last_of_pixel
);

    localparam int DESC_W = $bits(pnt_pkg::pix_desc_t);
    localparam int RES_W  = $bits(pnt_pkg::result_t);

    // front -> descriptor queue
    pnt_pkg::pix_desc_t desc_in;
    pnt_pkg::pix_desc_t desc_out;
    logic               desc_push;
    logic               desc_pop;
    logic               desc_full;
    logic               desc_empty;
    logic [DESC_W-1:0]  desc_rd;
    pnt_pkg::coef_set_t coef;

    // back -> result queue
    pnt_pkg::result_t   res_in;
    pnt_pkg::result_t   res_out;
    logic               res_push;
    logic               res_full;
    logic [RES_W-1:0]   res_rd;

    assign full = desc_full;

    pnt_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .pixel_ch0 (pixel_ch0),
        .pixel_ch1 (pixel_ch1),
        .pixel_ch2 (pixel_ch2),
        .desc_full (desc_full),
        .desc_push (desc_push),
        .desc      (desc_in),
        .coef      (coef)
    );

    // two pixel words decouple the counter from the channel walk
    pnt_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (2)
    ) u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_in),
        .rd_en   (desc_pop),
        .rd_data (desc_rd),
        .full    (desc_full),
        .empty   (desc_empty)
    );

    assign desc_out = pnt_pkg::pix_desc_t'(desc_rd);

    pnt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc_out),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .coef       (coef),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    // result skid queue; lets the back end keep going while a word waits
    pnt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_rd),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_out        = pnt_pkg::result_t'(res_rd);
    assign norm_value     = $signed(res_out.value);
    assign tensor_address = res_out.addr;
    assign channel_index  = res_out.ch;
    assign clipped        = res_out.clipped;
    assign frame_end      = res_out.fend;
    assign last_of_pixel  = res_out.last;

endmodule

FILE: sv/pnt_fifo.sv
// Small register queue used between front and back and at the result side.
module pnt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/pnt_front.sv
// Front end: config registers, pixel counter, frame end and address setup.
module pnt_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pnt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pnt_pkg::COEF_W-1:0]           cfg_data,
    input  logic                                 push,
    input  logic [pnt_pkg::PIX_W-1:0]            pixel_ch0,
    input  logic [pnt_pkg::PIX_W-1:0]            pixel_ch1,
    input  logic [pnt_pkg::PIX_W-1:0]            pixel_ch2,
    input  logic                                 desc_full,
    output logic                                 desc_push,
    output pnt_pkg::pix_desc_t                   desc,
    output pnt_pkg::coef_set_t                   coef
);

    localparam int MD_W = $clog2(MAX_DIM + 1) + 1;
    localparam int CMP_W = (MD_W > pnt_pkg::DIM_W) ? MD_W : pnt_pkg::DIM_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    logic                          three_channel_reg;
    logic                          interleaved_reg;
    logic [pnt_pkg::DIM_W-1:0]     width_reg;
    logic [pnt_pkg::DIM_W-1:0]     height_reg;
    pnt_pkg::coef_set_t            coef_reg;
    logic [pnt_pkg::COUNT_W-1:0]   pixel_count_reg;
    logic [pnt_pkg::COUNT_W-1:0]   pixel_count_next;

    logic [pnt_pkg::DIM_W-1:0]     width_c;
    logic [pnt_pkg::DIM_W-1:0]     height_c;
    logic [pnt_pkg::ADDR_W-1:0]    plane;
    logic [pnt_pkg::ADDR_W-1:0]    pix_ext;
    logic [pnt_pkg::ADDR_W-1:0]    pix_inc;
    logic                          fend;

    function automatic logic [pnt_pkg::DIM_W-1:0] clamp_dim(
        input logic [pnt_pkg::DIM_W-1:0] d
    );
        logic [pnt_pkg::DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = pnt_pkg::DIM_W'(1);
        end
        else if (CMP_W'(d) > MAX_DIM_C)
        begin
            r = pnt_pkg::DIM_W'(MAX_DIM_C);
        end
        return r;
    endfunction

    assign width_c  = clamp_dim(width_reg);
    assign height_c = clamp_dim(height_reg);
    // 13 x 13 product, below 2^26 for any clamped size
    assign plane    = pnt_pkg::ADDR_W'(width_c) * pnt_pkg::ADDR_W'(height_c);
    assign pix_ext  = pnt_pkg::ADDR_W'(pixel_count_reg);
    assign pix_inc  = pix_ext + 1'b1;
    assign fend     = (pix_inc >= plane);

    assign desc_push = push && !desc_full;
    assign coef      = coef_reg;

    always_comb
    begin
        desc.pixel[0] = pixel_ch0;
        desc.pixel[1] = pixel_ch1;
        desc.pixel[2] = pixel_ch2;
        desc.three    = three_channel_reg;
        desc.fend     = fend;
        if (interleaved_reg)
        begin
            desc.addr_start = three_channel_reg ? (pix_ext + {pix_ext[pnt_pkg::ADDR_W-2:0], 1'b0})
                                                : pix_ext;
            desc.addr_step  = pnt_pkg::ADDR_W'(1);
        end
        else
        begin
            desc.addr_start = pix_ext;
            desc.addr_step  = plane;
        end
        pixel_count_next = fend ? '0 : pix_inc[pnt_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_channel_reg <= 1'b1;
            interleaved_reg   <= 1'b0;
            width_reg         <= pnt_pkg::DIM_RST;
            height_reg        <= pnt_pkg::DIM_RST;
            coef_reg          <= {pnt_pkg::NUM_CH{pnt_pkg::COEF_RST}};
            pixel_count_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (pnt_pkg::cfg_idx_t'(cfg_index))
                    pnt_pkg::CFG_THREE_CH:    three_channel_reg <= cfg_data[0];
                    pnt_pkg::CFG_INTERLEAVED: interleaved_reg   <= cfg_data[0];
                    pnt_pkg::CFG_WIDTH:       width_reg  <= cfg_data[pnt_pkg::DIM_W-1:0];
                    pnt_pkg::CFG_HEIGHT:      height_reg <= cfg_data[pnt_pkg::DIM_W-1:0];
                    pnt_pkg::CFG_CH0_COEF:    coef_reg[0] <= cfg_data;
                    pnt_pkg::CFG_CH1_COEF:    coef_reg[1] <= cfg_data;
                    pnt_pkg::CFG_CH2_COEF:    coef_reg[2] <= cfg_data;
                    default:                  ;
                endcase
            end
            if (desc_push)
            begin
                pixel_count_reg <= pixel_count_next;
            end
        end
    end

endmodule

FILE: sv/pnt_back.sv
// Back end: walks the channels of a pixel, multiplies, subtracts the offset, saturates.
module pnt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pnt_pkg::pix_desc_t   desc,
    input  logic                 desc_empty,
    output logic                 desc_pop,
    input  pnt_pkg::coef_set_t   coef,
    input  logic                 res_full,
    output logic                 res_push,
    output pnt_pkg::result_t     res
);

    logic [pnt_pkg::CH_W-1:0]            ch_reg;
    logic [pnt_pkg::ADDR_W-1:0]          addr_run_reg;
    logic                                s1_valid_reg;
    logic signed [pnt_pkg::PROD_W-1:0]   s1_prod_reg;
    logic signed [pnt_pkg::VAL_W-1:0]    s1_offs_reg;
    logic [pnt_pkg::ADDR_W-1:0]          s1_addr_reg;
    logic [pnt_pkg::CH_W-1:0]            s1_ch_reg;
    logic                                s1_fend_reg;
    logic                                s1_last_reg;

    logic                                s1_ready;
    logic                                issue;
    logic                                last_ch;
    logic [pnt_pkg::COEF_W-1:0]          coef_sel;
    logic [pnt_pkg::PIX_W-1:0]           pix_sel;
    logic signed [pnt_pkg::VAL_W-1:0]    gain;
    logic [pnt_pkg::ADDR_W-1:0]          addr_cur;
    logic signed [pnt_pkg::DIFF_W-1:0]   diff;
    logic                                ovf;

    assign s1_ready = !s1_valid_reg || !res_full;
    assign issue    = !desc_empty && s1_ready;
    assign last_ch  = !desc.three || (ch_reg == pnt_pkg::CH_2);
    assign desc_pop = issue && last_ch;
    assign addr_cur = (ch_reg == pnt_pkg::CH_0) ? desc.addr_start : addr_run_reg;
    assign gain     = $signed(coef_sel[pnt_pkg::COEF_W-1:pnt_pkg::VAL_W]);

    always_comb
    begin
        case (pnt_pkg::ch_t'(ch_reg))
            pnt_pkg::CH_0:
            begin
                coef_sel = coef[0];
                pix_sel  = desc.pixel[0];
            end
            pnt_pkg::CH_1:
            begin
                coef_sel = coef[1];
                pix_sel  = desc.pixel[1];
            end
            default:
            begin
                coef_sel = coef[2];
                pix_sel  = desc.pixel[2];
            end
        endcase
    end

    // stage 1 holds the raw product; subtract and clamp feed the result queue
    assign diff = pnt_pkg::DIFF_W'(s1_prod_reg) - pnt_pkg::DIFF_W'(s1_offs_reg);
    assign ovf  = !((&diff[pnt_pkg::DIFF_W-1:pnt_pkg::VAL_W-1])
                 || !(|diff[pnt_pkg::DIFF_W-1:pnt_pkg::VAL_W-1]));

    assign res_push = s1_valid_reg && !res_full;

    always_comb
    begin
        if (ovf)
        begin
            res.value = diff[pnt_pkg::DIFF_W-1] ? pnt_pkg::VAL_MIN : pnt_pkg::VAL_MAX;
        end
        else
        begin
            res.value = diff[pnt_pkg::VAL_W-1:0];
        end
        res.addr    = s1_addr_reg;
        res.ch      = s1_ch_reg;
        res.clipped = ovf;
        res.fend    = s1_fend_reg;
        res.last    = s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_prod_reg  <= pnt_pkg::PROD_W'($signed({1'b0, pix_sel}))
                          * pnt_pkg::PROD_W'(gain);
            s1_offs_reg  <= $signed(coef_sel[pnt_pkg::VAL_W-1:0]);
            s1_addr_reg  <= addr_cur;
            s1_ch_reg    <= ch_reg;
            s1_fend_reg  <= desc.fend;
            s1_last_reg  <= last_ch;
            addr_run_reg <= addr_cur + desc.addr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (issue)
            begin
                ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
            end
        end
    end

endmodule
